>>> rtl/are_pkg.sv
// ----------------------------------------------------------------------------
// are_pkg - ARP resolver engine shared types and constants
// Command, frame and result codes, payload beat structs, controller bundles.
// ----------------------------------------------------------------------------
package are_pkg;

  localparam int CacheEntriesDef = 16;
  localparam int WaitTargetsDef  = 8;
  localparam int QueueDepthDef   = 8;

  localparam logic [47:0] MacBcast = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] AgeMax   = 16'hFFFF;

  localparam logic [1:0] CmdSend = 2'd0;
  localparam logic [1:0] CmdRecv = 2'd1;
  localparam logic [1:0] CmdTick = 2'd2;
  localparam logic [1:0] CmdRsvd = 2'd3;

  localparam logic [1:0] KindIpv4  = 2'd0;
  localparam logic [1:0] KindArp   = 2'd1;
  localparam logic [1:0] KindOther = 2'd2;

  localparam logic [1:0] OpRequest = 2'd0;
  localparam logic [1:0] OpReply   = 2'd1;

  localparam logic [1:0] OutIpv4    = 2'd0;
  localparam logic [1:0] OutArpReq  = 2'd1;
  localparam logic [1:0] OutArpRep  = 2'd2;
  localparam logic [1:0] OutDeliver = 2'd3;

  localparam logic [1:0] RegOwnMac = 2'd0;
  localparam logic [1:0] RegOwnIp  = 2'd1;
  localparam logic [1:0] RegCttl   = 2'd2;
  localparam logic [1:0] RegRttl   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] payload_handle;
    logic [31:0] gateway_ip;
    logic [47:0] frame_dst_mac;
    logic [1:0]  frame_kind;
    logic        parse_ok;
    logic [1:0]  arp_op;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [47:0] dest_mac;
    logic [31:0] query_ip;
    logic [47:0] query_mac;
    logic [15:0] out_handle;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item
    logic cscan;      // cache scan step
    logic wscan;      // wait table scan step
    logic learn;      // write learned entry
    logic send_upd;   // apply send result to wait table
    logic flush_rd;   // read queue entry
    logic flush_clr;  // free matched wait slot
    logic clr_idx;    // reset scan index
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cdone;
    logic wdone;
    logic chit;
    logic whit;
    logic wfree;
    logic qroom;
    logic qdone;
    logic filt_ok;
    logic reply;
  } dp_sts_t;

endpackage

>>> rtl/are_datapath.sv
// ----------------------------------------------------------------------------
// are_datapath - tables, scan index and result formatting
// Cache and pending tables are walked one entry a cycle by the controller.
// ----------------------------------------------------------------------------
module are_datapath #(
  parameter int CACHE_ENTRIES = are_pkg::CacheEntriesDef,
  parameter int WAIT_TARGETS  = are_pkg::WaitTargetsDef,
  parameter int QUEUE_DEPTH   = are_pkg::QueueDepthDef
) (
  input  logic              clk,
  input  logic              rst,
  input  are_pkg::in_item_t item,
  input  are_pkg::dp_cmd_t  cmd,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [47:0]       cfg_data,
  input  logic [1:0]        emit_kind,
  input  logic              emit,
  input  logic              emit_last,
  output are_pkg::dp_sts_t  sts,
  output are_pkg::out_item_t res
);
  import are_pkg::*;

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int WW = (WAIT_TARGETS > 1) ? $clog2(WAIT_TARGETS) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (CW > WW ? CW : WW) + 1;
  localparam int AW = (WAIT_TARGETS * QUEUE_DEPTH > 1) ?
                      $clog2(WAIT_TARGETS * QUEUE_DEPTH) : 1;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [15:0] cache_ttl, req_ttl;

  in_item_t it;

  logic [CACHE_ENTRIES-1:0] cache_used;
  logic [31:0] cache_ip  [CACHE_ENTRIES];
  logic [47:0] cache_mac [CACHE_ENTRIES];
  logic [15:0] cache_age [CACHE_ENTRIES];

  logic [WAIT_TARGETS-1:0] wait_used;
  logic [31:0] wait_ip    [WAIT_TARGETS];
  logic [15:0] wait_age   [WAIT_TARGETS];
  logic [NW-1:0] wait_count [WAIT_TARGETS];
  logic [15:0] wait_handles [WAIT_TARGETS * QUEUE_DEPTH];

  logic [IW-1:0] idx;
  logic [CW-1:0] ci;
  logic [WW-1:0] wi;

  // scan results
  logic          chit;
  logic [CW-1:0] chit_idx;
  logic          cfree;
  logic [CW-1:0] cfree_idx;
  logic [CW-1:0] old_idx;
  logic [15:0]   old_age;
  logic [47:0]   hit_mac;
  logic          whit;
  logic [WW-1:0] whit_idx;
  logic          wfree;
  logic [WW-1:0] wfree_idx;
  logic [NW-1:0] qpos;
  logic [15:0]   qdata;

  logic [31:0] key_ip;
  logic [16:0] csum, wsum;
  logic [15:0] cage_n, wage_n;
  logic [CW-1:0] lslot;

  // queue store addresses: append, first entry of a new queue, flush read
  logic [AW-1:0] q_wr_addr, q_new_addr, q_rd_addr;

  out_item_t res_next;

  assign ci = idx[CW-1:0];
  assign wi = idx[WW-1:0];
  assign key_ip = (it.cmd == CmdSend) ? it.gateway_ip : it.arp_sender_ip;
  assign csum = {1'b0, cache_age[ci]} + {1'b0, it.elapsed_ms};
  assign wsum = {1'b0, wait_age[wi]} + {1'b0, it.elapsed_ms};
  assign cage_n = csum[16] ? AgeMax : csum[15:0];
  assign wage_n = wsum[16] ? AgeMax : wsum[15:0];
  assign lslot = chit ? chit_idx : (cfree ? cfree_idx : old_idx);

  assign q_wr_addr  = AW'(whit_idx) * AW'(QUEUE_DEPTH) + AW'(wait_count[whit_idx]);
  assign q_new_addr = AW'(wfree_idx) * AW'(QUEUE_DEPTH);
  assign q_rd_addr  = AW'(whit_idx) * AW'(QUEUE_DEPTH) + AW'(qpos);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac    <= '0;
      own_ip     <= '0;
      cache_ttl  <= 16'd30000;
      req_ttl    <= 16'd5000;
      cache_used <= '0;
      wait_used  <= '0;
      idx        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          RegOwnMac: own_mac   <= cfg_data;
          RegOwnIp:  own_ip    <= cfg_data[31:0];
          RegCttl:   cache_ttl <= cfg_data[15:0];
          RegRttl:   req_ttl   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        it <= item;
      end
      if (cmd.clr_idx) begin
        idx <= '0;
        if (cmd.load) begin
          chit <= 1'b0; cfree <= 1'b0; old_idx <= '0; old_age <= '0;
          whit <= 1'b0; wfree <= 1'b0; qpos <= '0;
        end
      end else if (cmd.cscan || cmd.wscan || cmd.flush_rd) begin
        idx <= idx + 1'b1;
      end
      if (cmd.cscan) begin
        if (it.cmd == CmdTick) begin
          if (cache_used[ci]) begin
            cache_age[ci] <= cage_n;
            if (cage_n >= cache_ttl) cache_used[ci] <= 1'b0;
          end
        end else begin
          if (cache_used[ci] && cache_ip[ci] == key_ip && !chit) begin
            chit <= 1'b1; chit_idx <= ci; hit_mac <= cache_mac[ci];
          end
          if (!cache_used[ci] && !cfree) begin
            cfree <= 1'b1; cfree_idx <= ci;
          end
          if (idx == '0 || cache_age[ci] > old_age) begin
            old_idx <= ci; old_age <= cache_age[ci];
          end
        end
      end
      if (cmd.wscan) begin
        if (it.cmd == CmdTick) begin
          if (wait_used[wi]) begin
            wait_age[wi] <= wage_n;
            if (wage_n >= req_ttl) wait_used[wi] <= 1'b0;
          end
        end else begin
          if (wait_used[wi] && wait_ip[wi] == key_ip && !whit) begin
            whit <= 1'b1; whit_idx <= wi;
          end
          if (!wait_used[wi] && !wfree) begin
            wfree <= 1'b1; wfree_idx <= wi;
          end
        end
      end
      if (cmd.learn) begin
        cache_used[lslot] <= 1'b1;
        cache_ip[lslot]   <= it.arp_sender_ip;
        cache_mac[lslot]  <= it.arp_sender_mac;
        cache_age[lslot]  <= '0;
      end
      if (cmd.send_upd) begin
        if (whit) begin
          wait_handles[q_wr_addr] <= it.payload_handle;
          wait_count[whit_idx]    <= wait_count[whit_idx] + 1'b1;
        end else begin
          wait_used[wfree_idx]     <= 1'b1;
          wait_ip[wfree_idx]       <= it.gateway_ip;
          wait_age[wfree_idx]      <= '0;
          wait_count[wfree_idx]    <= NW'(1);
          wait_handles[q_new_addr] <= it.payload_handle;
        end
      end
      if (cmd.flush_rd) begin
        qdata <= wait_handles[q_rd_addr];
        qpos  <= qpos + 1'b1;
      end
      if (cmd.flush_clr) wait_used[whit_idx] <= 1'b0;
    end
  end

  always_comb begin
    sts.cdone   = (idx == IW'(CACHE_ENTRIES - 1));
    sts.wdone   = (idx == IW'(WAIT_TARGETS - 1));
    sts.chit    = chit;
    sts.whit    = whit;
    sts.wfree   = wfree;
    sts.qroom   = whit ? (wait_count[whit_idx] < NW'(QUEUE_DEPTH)) : 1'b1;
    sts.qdone   = whit ? (qpos >= wait_count[whit_idx]) : 1'b1;
    sts.filt_ok = (it.frame_dst_mac == own_mac || it.frame_dst_mac == MacBcast)
                  && it.parse_ok;
    sts.reply   = (it.arp_op == OpRequest) && (it.arp_target_ip == own_ip);
  end

  // unused fields of a beat stay zero
  always_comb begin
    res_next          = '0;
    res_next.out_kind = emit_kind;
    res_next.last     = emit_last;
    unique case (emit_kind)
      OutIpv4: begin
        res_next.dest_mac   = (it.cmd == CmdSend) ? hit_mac : it.arp_sender_mac;
        res_next.out_handle = (it.cmd == CmdSend) ? it.payload_handle : qdata;
      end
      OutArpReq: begin
        res_next.dest_mac = MacBcast;
        res_next.query_ip = it.gateway_ip;
      end
      OutArpRep: begin
        res_next.dest_mac  = it.arp_sender_mac;
        res_next.query_ip  = it.arp_sender_ip;
        res_next.query_mac = it.arp_sender_mac;
      end
      default: res_next.out_handle = it.payload_handle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) res <= res_next;
  end

endmodule

>>> rtl/are_ctrl.sv
// ----------------------------------------------------------------------------
// are_ctrl - sequencer for send, receive and tick
// Steps the datapath through cache and pending-table walks and result beats.
// ----------------------------------------------------------------------------
module are_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        item_cmd,
  input  logic [1:0]        item_kind,
  input  are_pkg::dp_sts_t  sts,
  output logic              busy,
  output are_pkg::dp_cmd_t  cmd,
  output logic              emit,
  output logic [1:0]        emit_kind,
  output logic              emit_last,
  output logic              strobe
);
  import are_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CSCAN, S_WSCAN, S_DECIDE, S_LEARN,
    S_FLUSH_RD, S_FLUSH_EMIT, S_REPLY, S_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    emit = 1'b0; emit_kind = OutIpv4; emit_last = 1'b0;
    cmd.load    = (state == S_IDLE) && start;
    cmd.clr_idx = cmd.load || state == S_DISPATCH
                  || (state == S_CSCAN && sts.cdone);
    unique case (state)
      S_CSCAN: cmd.cscan = 1'b1;
      S_WSCAN: cmd.wscan = 1'b1;
      S_DECIDE: begin
        if (item_cmd == CmdSend) begin
          if (sts.chit) begin
            emit = 1'b1; emit_kind = OutIpv4; emit_last = 1'b1;
          end else if (sts.whit) begin
            cmd.send_upd = sts.qroom;
          end else if (sts.wfree) begin
            cmd.send_upd = 1'b1;
            emit = 1'b1; emit_kind = OutArpReq; emit_last = 1'b1;
          end
        end
      end
      S_LEARN: cmd.learn = 1'b1;
      S_FLUSH_RD: cmd.flush_rd = 1'b1;
      S_FLUSH_EMIT: begin
        emit = 1'b1; emit_kind = OutIpv4;
        emit_last = sts.qdone && !sts.reply;
      end
      S_REPLY: begin
        cmd.flush_clr = sts.whit;
        if (sts.reply) begin
          emit = 1'b1; emit_kind = OutArpRep; emit_last = 1'b1;
        end
      end
      S_DISPATCH: begin
        if (item_cmd == CmdRecv && sts.filt_ok && item_kind == KindIpv4) begin
          emit = 1'b1; emit_kind = OutDeliver; emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      strobe  <= 1'b0;
    end else begin
      strobe <= emit;
      unique case (state)
        S_IDLE: if (start) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (item_cmd == CmdSend || item_cmd == CmdTick) state <= S_CSCAN;
          else if (item_cmd == CmdRecv && sts.filt_ok && item_kind == KindArp)
            state <= S_CSCAN;
          else state <= S_DONE;
        end
        S_CSCAN: if (sts.cdone) state <= S_WSCAN;
        S_WSCAN: begin
          if (sts.wdone) begin
            if (item_cmd == CmdTick) state <= S_DONE;
            else if (item_cmd == CmdSend) state <= S_DECIDE;
            else state <= S_LEARN;
          end
        end
        S_DECIDE: state <= S_DONE;
        S_LEARN: state <= sts.qdone ? S_REPLY : S_FLUSH_RD;
        S_FLUSH_RD: state <= S_FLUSH_EMIT;
        S_FLUSH_EMIT: state <= sts.qdone ? S_REPLY : S_FLUSH_RD;
        S_REPLY: state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/arp_resolver_engine_top.sv
// ----------------------------------------------------------------------------
// arp_resolver_engine_top - ARP resolver with aging cache and pending queues
// Top level: joins the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and pulse start while busy is low; the beat
//   is taken at that edge and busy rises right after it.
//   Results: each result beat sits on result for one cycle with strobe high;
//   the receiver cannot stall, so it must take every beat. result.last marks
//   the final beat of a command. Sends that are dropped, ticks and filtered
//   frames give no beat.
//   Config: cfg_we/cfg_index/cfg_data write own_mac, own_ip, cache_ttl_ms,
//   request_ttl_ms (index 0..3); the user writes only while idle, unchecked.
//   Sequence: filtered or delivered frames pass only the dispatch and done
//   states. Send, tick and ARP walk the cache (CACHE_ENTRIES entries), then
//   the pending table (WAIT_TARGETS entries), one entry per cycle. A tick
//   then ends; a send takes a decide step, and an ARP frame a learn step,
//   a read and an emit step per flushed queued datagram and a reply step.
//   The table walk sets the rate; a new command is taken only once idle.
//   Reset: synchronous; clears valid bits and restores TTL defaults. No
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_resolver_engine_top #(
  parameter int CACHE_ENTRIES = are_pkg::CacheEntriesDef,
  parameter int WAIT_TARGETS  = are_pkg::WaitTargetsDef,
  parameter int QUEUE_DEPTH   = are_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  are_pkg::in_item_t  item,
  output logic               strobe,
  output are_pkg::out_item_t result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);
  import are_pkg::*;

  dp_cmd_t   dcmd;
  dp_sts_t   sts;
  logic      emit, emit_last;
  logic [1:0] emit_kind;
  in_item_t  held;

  // controller needs the captured command; item is held in datapath, so
  // keep a small copy of the dispatch codes here
  logic [1:0] hcmd, hkind;
  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      hcmd  <= item.cmd;
      hkind <= item.frame_kind;
    end
  end
  assign held = item;

  are_ctrl u_ctrl (
    .clk, .rst, .start,
    .item_cmd  (hcmd),
    .item_kind (hkind),
    .sts, .busy, .cmd(dcmd), .emit, .emit_kind, .emit_last, .strobe
  );

  are_datapath #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .WAIT_TARGETS (WAIT_TARGETS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dp (
    .clk, .rst,
    .item     (held),
    .cmd      (dcmd),
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .emit_kind, .emit, .emit_last,
    .sts,
    .res      (result)
  );

  // a beat only appears while an item is in work
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result beat while idle");
  // no start is taken while busy; an accepted start must raise busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");
  // last ends a command: no beat follows it directly
  assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("beat after last");

endmodule
